// ----- hdl/nested_zone_time_profiler_defines.svh -----
// ---------------------------------------------------------------------------
// Nested zone time profiler: assertion macros
// Shorthand for the concurrent checks of the profiler, clocked on clk and
// quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef NESTED_ZONE_TIME_PROFILER_DEFINES_SVH
`define NESTED_ZONE_TIME_PROFILER_DEFINES_SVH

// A condition that must hold at every clock edge.
`define NZP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define NZP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define NZP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/nzp_pkg.sv -----
// ---------------------------------------------------------------------------
// Nested zone time profiler package
// Sizes, codes, table and stack entry types shared by the profiler.
// ---------------------------------------------------------------------------
package nzp_pkg;

  localparam int ZONE_COUNT = 64;
  localparam int NEST_DEPTH = 16;

  localparam int ZONE_W   = 6;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 64;

  localparam int ZONE_AW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int STK_AW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int LVL_W   = $clog2(NEST_DEPTH + 1);

  // Event kinds; the unused code behaves as a read.
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } nzp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_PARENT
  } nzp_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] excl;
    logic [DATA_W-1:0] incl;
    logic [DATA_W-1:0] hits;
    logic [DATA_W-1:0] bytes;
  } zone_entry_t;

  typedef struct packed {
    logic [ZONE_AW-1:0] parent;
    logic [DATA_W-1:0]  old_incl;
    logic [DATA_W-1:0]  start_time;
  } stack_entry_t;

  // Zone numbers beyond the table wrap onto it.
  function automatic logic [ZONE_AW-1:0] zone_index(input logic [ZONE_W-1:0] z);
    return ZONE_AW'(z % ZONE_COUNT);
  endfunction

endpackage

// ----- hdl/nzp_ram.sv -----
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data; a read of the
// address being written returns the old contents.
// ---------------------------------------------------------------------------
module nzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/nested_zone_time_profiler.sv -----
// ---------------------------------------------------------------------------
// Nested zone time profiler
// Per-zone exclusive time, inclusive time, hit and byte counters kept in a
// zone table RAM, with the open zones held on a stack RAM.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------
//   input     start / busy         in_kind, in_zone, in_timestamp,
//                                  in_byte_count
//   result    out_valid (strobe)   out_status, out_result_zone,
//                                  out_exclusive_time, out_inclusive_time,
//                                  out_hits, out_bytes_total
//
// A begin, a read or a failed end passes from the accepting cycle through
// S_UPDATE to idle; a successful end also passes S_PARENT, as it must
// read-modify-write two zone table entries with one table read and write port.
// The result appears on the output registers, with out_valid high for one
// cycle, in the first cycle in which busy is low again; the next transaction
// may be accepted in that same cycle. The receiver cannot stall the result side.
// Reset is synchronous and active low; it clears the stack level, the current
// zone and one valid bit per table entry, so no clearing pass is needed and
// the block accepts work in the first cycle after reset.
//
// Sequencing: in the accepting cycle the table entry (and the stack top, used
// by an end) is read. In S_UPDATE the entry returns, is modified and written
// back, and for a successful end the parent's entry is read. In S_PARENT the
// parent's exclusive time is reduced by the elapsed time. When the parent is
// the zone just ended, the freshly written entry is forwarded, because the
// table read in S_UPDATE would otherwise see the old contents.
// ---------------------------------------------------------------------------
`include "nested_zone_time_profiler_defines.svh"

module nested_zone_time_profiler
  import nzp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ZONE_W-1:0]   in_zone,
  input  logic [DATA_W-1:0]   in_timestamp,
  input  logic [DATA_W-1:0]   in_byte_count,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [ZONE_W-1:0]   out_result_zone,
  output logic [DATA_W-1:0]   out_exclusive_time,
  output logic [DATA_W-1:0]   out_inclusive_time,
  output logic [DATA_W-1:0]   out_hits,
  output logic [DATA_W-1:0]   out_bytes_total
);

  // Sequencer state.
  nzp_state_t state_r, state_nxt;

  // Control state, cleared by reset.
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic [ZONE_AW-1:0]    cur_zone_r, cur_zone_nxt;
  logic [ZONE_COUNT-1:0] zvalid_r, zvalid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Transaction payload held while the sequencer runs.
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ZONE_AW-1:0] tzone_r, tzone_nxt;
  logic [DATA_W-1:0]  ts_r, ts_nxt;
  logic [DATA_W-1:0]  bytes_r, bytes_nxt;
  logic               rd_valid_r, rd_valid_nxt;
  zone_entry_t        self_r, self_nxt;
  logic [DATA_W-1:0]  elapsed_r, elapsed_nxt;
  logic [ZONE_AW-1:0] parent_r, parent_nxt;
  logic               same_r, same_nxt;

  // Result registers.
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ZONE_W-1:0]   out_zone_r, out_zone_nxt;
  zone_entry_t         out_entry_r, out_entry_nxt;

  // Zone table port.
  logic               tbl_re, tbl_we;
  logic [ZONE_AW-1:0] tbl_raddr, tbl_waddr;
  zone_entry_t        tbl_rdata, tbl_wdata;

  // Stack port.
  logic               stk_re, stk_we;
  logic [STK_AW-1:0]  stk_raddr, stk_waddr;
  stack_entry_t       stk_rdata, stk_wdata;

  // Working values.
  logic [LVL_W-1:0]   level_m1;
  zone_entry_t        tbl_entry;
  zone_entry_t        parent_entry;
  zone_entry_t        parent_new;
  zone_entry_t        self_new;
  logic [DATA_W-1:0]  elapsed;
  logic               stack_full;
  logic               stack_empty;

  nzp_ram #(
    .WIDTH ($bits(zone_entry_t)),
    .DEPTH (ZONE_COUNT)
  ) u_zone_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  nzp_ram #(
    .WIDTH ($bits(stack_entry_t)),
    .DEPTH (NEST_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign busy        = (state_r != S_IDLE);
  assign level_m1    = level_r - LVL_W'(1);
  assign stack_full  = (level_r >= LVL_W'(NEST_DEPTH));
  assign stack_empty = (level_r == LVL_W'(0));

  // An entry that has never been written reads as zero.
  assign tbl_entry = rd_valid_r ? tbl_rdata : '0;

  // Elapsed time and the ended zone's new counters.
  always_comb begin
    elapsed       = ts_r - stk_rdata.start_time;
    self_new      = tbl_entry;
    self_new.excl = tbl_entry.excl + elapsed;
    self_new.incl = stk_rdata.old_incl + elapsed;
    self_new.hits = tbl_entry.hits + DATA_W'(1);
  end

  // Parent entry, forwarded from the ended zone when both are the same.
  always_comb begin
    parent_entry    = same_r ? self_r : tbl_entry;
    parent_new      = parent_entry;
    parent_new.excl = parent_entry.excl - elapsed_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (kind_r == KIND_END && !stack_empty) begin
          state_nxt = S_PARENT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PARENT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory accesses, datapath and results.
  always_comb begin
    level_nxt      = level_r;
    cur_zone_nxt   = cur_zone_r;
    out_valid_nxt  = 1'b0;
    kind_nxt       = kind_r;
    tzone_nxt      = tzone_r;
    ts_nxt         = ts_r;
    bytes_nxt      = bytes_r;
    rd_valid_nxt   = rd_valid_r;
    self_nxt       = self_r;
    elapsed_nxt    = elapsed_r;
    parent_nxt     = parent_r;
    same_nxt       = same_r;
    out_status_nxt = out_status_r;
    out_zone_nxt   = out_zone_r;
    out_entry_nxt  = out_entry_r;

    tbl_re    = 1'b0;
    tbl_raddr = tzone_r;
    tbl_we    = 1'b0;
    tbl_waddr = tzone_r;
    tbl_wdata = tbl_entry;
    stk_re    = 1'b0;
    stk_raddr = level_m1[STK_AW-1:0];
    stk_we    = 1'b0;
    stk_waddr = level_r[STK_AW-1:0];
    stk_wdata = '{parent: cur_zone_r, old_incl: tbl_entry.incl, start_time: ts_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          ts_nxt    = in_timestamp;
          bytes_nxt = in_byte_count;
          tbl_re    = 1'b1;
          stk_re    = 1'b1;
          if (in_kind == KIND_END) begin
            tbl_raddr = cur_zone_r;
          end else begin
            tbl_raddr = zone_index(in_zone);
          end
          tzone_nxt    = tbl_raddr;
          rd_valid_nxt = zvalid_r[tbl_raddr];
        end
      end

      S_UPDATE: begin
        out_zone_nxt   = ZONE_W'(tzone_r);
        out_status_nxt = ST_OK;
        out_entry_nxt  = tbl_entry;
        case (kind_r)
          KIND_BEGIN: begin
            out_valid_nxt = 1'b1;
            if (stack_full) begin
              out_status_nxt = ST_OVERFLOW;
            end else begin
              tbl_we          = 1'b1;
              tbl_wdata.bytes = tbl_entry.bytes + bytes_r;
              stk_we          = 1'b1;
              level_nxt       = level_r + LVL_W'(1);
              cur_zone_nxt    = tzone_r;
              out_entry_nxt   = tbl_wdata;
            end
          end
          KIND_END: begin
            if (stack_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_UNDERFLOW;
            end else begin
              tbl_we       = 1'b1;
              tbl_wdata    = self_new;
              self_nxt     = self_new;
              elapsed_nxt  = elapsed;
              parent_nxt   = stk_rdata.parent;
              same_nxt     = (stk_rdata.parent == tzone_r);
              tbl_re       = 1'b1;
              tbl_raddr    = stk_rdata.parent;
              rd_valid_nxt = zvalid_r[stk_rdata.parent];
              level_nxt    = level_m1;
              cur_zone_nxt = stk_rdata.parent;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      S_PARENT: begin
        tbl_we         = 1'b1;
        tbl_waddr      = parent_r;
        tbl_wdata      = parent_new;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_zone_nxt   = ZONE_W'(tzone_r);
        out_entry_nxt  = same_r ? parent_new : self_r;
      end

      default: begin
      end
    endcase

    zvalid_nxt = zvalid_r;
    if (tbl_we) begin
      zvalid_nxt[tbl_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      cur_zone_r  <= '0;
      zvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      cur_zone_r  <= cur_zone_nxt;
      zvalid_r    <= zvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tzone_r      <= tzone_nxt;
    ts_r         <= ts_nxt;
    bytes_r      <= bytes_nxt;
    rd_valid_r   <= rd_valid_nxt;
    self_r       <= self_nxt;
    elapsed_r    <= elapsed_nxt;
    parent_r     <= parent_nxt;
    same_r       <= same_nxt;
    out_status_r <= out_status_nxt;
    out_zone_r   <= out_zone_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_zone    = out_zone_r;
  assign out_exclusive_time = out_entry_r.excl;
  assign out_inclusive_time = out_entry_r.incl;
  assign out_hits           = out_entry_r.hits;
  assign out_bytes_total    = out_entry_r.bytes;

  // The stack level never passes the nesting depth.
  `NZP_ASSERT_ALWAYS(a_level_bound, level_r <= LVL_W'(NEST_DEPTH), "stack level beyond depth")
  // A push only happens while the stack has room.
  `NZP_ASSERT_SAME(a_push_room, stk_we, !stack_full, "push into a full stack")
  // A result is shown only once the sequencer has returned to idle.
  `NZP_ASSERT_SAME(a_result_idle, out_valid, !busy, "result while sequencer busy")
  // A successful end always goes on to the parent update.
  `NZP_ASSERT_NEXT(a_end_parent, state_r == S_UPDATE && kind_r == KIND_END && !stack_empty,
                   state_r == S_PARENT && !out_valid, "end skipped the parent update")

endmodule
